@@ rtl/whm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the wildcard host-name matcher.
package whm_pkg;

    localparam int MAX_NAME_LEN_DEF = 256;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef enum logic [1:0] {
        CMD_APPEND_DOMAIN = 2'd0,
        CMD_APPEND_REF    = 2'd1,
        CMD_COMPARE       = 2'd2,
        CMD_NOP           = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_LOCK,
        ST_WILD,
        ST_FAIL,
        ST_PASS
    } t_state;

    typedef struct packed {
        logic append_d;
        logic append_p;
        logic start;
        logic dec_d;
        logic dec_p;
        logic capture;
        logic finish;
        logic verdict;
        logic busy;
    } t_dp_cmd;

    typedef struct packed {
        logic d_zero;
        logic p_zero;
        logic d_one;
        logic p_one;
        logic d_end;
        logic p_end;
        logic d_name;
        logic eq_fold;
        logic first_star;
        logic first_name;
        logic first_eq;
        logic ovf;
        logic dtext_zero;
        logic ptext_zero;
        logic out_valid;
    } t_dp_status;

    function automatic logic is_name_char(input logic [7:0] c);
        is_name_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                       (c >= 8'h41 && c <= 8'h5A) || (c == CH_DASH);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        fold_case = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
    endfunction

endpackage

@@ rtl/wildcard_hostname_match_top.sv @@
`timescale 1ns / 1ps
// Append words are accepted back to back.
// A compare walks both stores from the right through one registered read port each and
// then presents its result word; an empty text or an overflowed store skips the walk.
// Input is held off during a walk, and a compare also waits for a free result register.
// Synchronous active-low reset clears counters, overflow flag and result valid; stores keep data.
module wildcard_hostname_match_top import whm_pkg::*; #(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_matched,
    output logic       o_too_long
);

    t_dp_cmd    ctrl_cmd;
    t_dp_status dp_status;

    whm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_out_ready (i_ready),
        .i_status    (dp_status),
        .o_ready     (o_ready),
        .o_cmd       (ctrl_cmd)
    );

    whm_datapath #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .i_char_byte (i_char_byte),
        .i_out_ready (i_ready),
        .o_status    (dp_status),
        .o_valid     (o_valid),
        .o_matched   (o_matched),
        .o_too_long  (o_too_long)
    );

    a_no_match_on_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_matched && o_too_long))
        else $error("Overflowed compare reported a match.");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.busy |-> !o_ready)
        else $error("Input word accepted during a compare walk.");

    a_finish_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.finish |=> o_valid)
        else $error("Finished compare did not present a result word.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result word valid straight after reset.");

endmodule

@@ rtl/whm_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the host-name matcher: both byte stores, counters, scan pointers and result word.
module whm_datapath import whm_pkg::*; #(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_char_byte,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_valid,
    output logic       o_matched,
    output logic       o_too_long
);

    localparam int AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
    localparam int CW = $clog2(MAX_NAME_LEN + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_NAME_LEN);
    localparam logic [CW-1:0] ONE  = CW'(1);

    logic [7:0] r_dmem [MAX_NAME_LEN];
    logic [7:0] r_pmem [MAX_NAME_LEN];

    logic [CW-1:0] r_dlen, r_plen, r_dtext, r_ptext, r_dcnt, r_pcnt;
    logic [CW-1:0] n_dcnt, n_pcnt;
    logic          r_dzero_seen, r_pzero_seen, r_ovf, r_snap;
    logic [7:0]    r_db, r_pb;
    logic          r_first_star, r_first_name, r_first_eq;
    logic          r_out_valid, r_matched, r_too_long;
    logic [AW-1:0] d_rd_addr, p_rd_addr;
    logic          d_full, p_full;

    assign d_full = (r_dlen == FULL);
    assign p_full = (r_plen == FULL);

    always_comb begin
        if (i_cmd.start) begin
            n_dcnt = r_dtext;
        end else if (i_cmd.dec_d) begin
            n_dcnt = r_dcnt - ONE;
        end else begin
            n_dcnt = r_dcnt;
        end
        if (i_cmd.start) begin
            n_pcnt = r_ptext;
        end else if (i_cmd.dec_p) begin
            n_pcnt = r_pcnt - ONE;
        end else begin
            n_pcnt = r_pcnt;
        end
    end

    assign d_rd_addr = AW'(n_dcnt - ONE);
    assign p_rd_addr = AW'(n_pcnt - ONE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.append_d && !d_full) begin
            r_dmem[r_dlen[AW-1:0]] <= i_char_byte;
        end
        r_db <= r_dmem[d_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append_p && !p_full) begin
            r_pmem[r_plen[AW-1:0]] <= i_char_byte;
        end
        r_pb <= r_pmem[p_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen       <= '0;
            r_plen       <= '0;
            r_dtext      <= '0;
            r_ptext      <= '0;
            r_dzero_seen <= 1'b0;
            r_pzero_seen <= 1'b0;
            r_ovf        <= 1'b0;
            r_dcnt       <= '0;
            r_pcnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_dcnt <= n_dcnt;
            r_pcnt <= n_pcnt;
            if (i_cmd.start) begin
                r_dlen       <= '0;
                r_plen       <= '0;
                r_dtext      <= '0;
                r_ptext      <= '0;
                r_dzero_seen <= 1'b0;
                r_pzero_seen <= 1'b0;
                r_ovf        <= 1'b0;
            end else begin
                if (i_cmd.append_d) begin
                    if (d_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_dlen <= r_dlen + ONE;
                        if (!r_dzero_seen) begin
                            if (i_char_byte == 8'd0) begin
                                r_dzero_seen <= 1'b1;
                            end else begin
                                r_dtext <= r_dtext + ONE;
                            end
                        end
                    end
                end
                if (i_cmd.append_p) begin
                    if (p_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_plen <= r_plen + ONE;
                        if (!r_pzero_seen) begin
                            if (i_char_byte == 8'd0) begin
                                r_pzero_seen <= 1'b1;
                            end else begin
                                r_ptext <= r_ptext + ONE;
                            end
                        end
                    end
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_snap <= r_ovf;
        end
        if (i_cmd.capture) begin
            r_first_star <= (r_pb == CH_STAR);
            r_first_name <= is_name_char(r_db);
            r_first_eq   <= (fold_case(r_db) == fold_case(r_pb));
        end
        if (i_cmd.finish) begin
            r_matched  <= i_cmd.verdict;
            r_too_long <= r_snap;
        end
    end

    always_comb begin
        o_status.d_zero     = (r_dcnt == '0);
        o_status.p_zero     = (r_pcnt == '0);
        o_status.d_one      = (r_dcnt == ONE);
        o_status.p_one      = (r_pcnt == ONE);
        o_status.d_end      = (r_dcnt == '0) || (r_db == CH_DOT);
        o_status.p_end      = (r_pcnt == '0) || (r_pb == CH_DOT);
        o_status.d_name     = is_name_char(r_db);
        o_status.eq_fold    = (fold_case(r_db) == fold_case(r_pb));
        o_status.first_star = r_first_star;
        o_status.first_name = r_first_name;
        o_status.first_eq   = r_first_eq;
        o_status.ovf        = r_ovf;
        o_status.dtext_zero = (r_dtext == '0);
        o_status.ptext_zero = (r_ptext == '0);
        o_status.out_valid  = r_out_valid;
    end

    assign o_valid    = r_out_valid;
    assign o_matched  = r_matched;
    assign o_too_long = r_too_long;

endmodule

@@ rtl/whm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the host-name matcher: input handshake and the right-to-left label scan.
module whm_ctrl import whm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_cmd   cmd;
    logic   out_free, accept, label_next, both_zero;

    assign cmd        = t_cmd'(i_command);
    assign out_free   = !i_status.out_valid || i_out_ready;
    assign o_ready    = (r_state == ST_IDLE) && ((cmd != CMD_COMPARE) || out_free);
    assign accept     = i_valid && o_ready;
    assign both_zero  = i_status.d_zero && i_status.p_zero;
    assign label_next = !i_status.d_zero && !i_status.p_zero &&
                        !i_status.d_one && !i_status.p_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && cmd == CMD_COMPARE) begin
                    if (i_status.ovf || i_status.dtext_zero || i_status.ptext_zero) begin
                        n_state = ST_FAIL;
                    end else begin
                        n_state = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                n_state = ST_SECOND;
            end
            ST_SECOND: begin
                if (i_status.first_star && i_status.p_end) begin
                    n_state = i_status.first_name ? ST_WILD : ST_FAIL;
                end else begin
                    n_state = (i_status.first_name && i_status.first_eq) ? ST_LOCK : ST_FAIL;
                end
            end
            ST_LOCK: begin
                if (i_status.d_end && i_status.p_end) begin
                    if (both_zero) begin
                        n_state = ST_PASS;
                    end else if (label_next) begin
                        n_state = ST_FIRST;
                    end else begin
                        n_state = ST_FAIL;
                    end
                end else if (i_status.d_end || i_status.p_end) begin
                    n_state = ST_FAIL;
                end else if (!(i_status.d_name && i_status.eq_fold)) begin
                    n_state = ST_FAIL;
                end
            end
            ST_WILD: begin
                if (i_status.d_end) begin
                    if (both_zero) begin
                        n_state = ST_PASS;
                    end else if (label_next) begin
                        n_state = ST_FIRST;
                    end else begin
                        n_state = ST_FAIL;
                    end
                end else if (!i_status.d_name) begin
                    n_state = ST_FAIL;
                end
            end
            ST_FAIL: begin
                n_state = ST_IDLE;
            end
            ST_PASS: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.append_d = accept && (cmd == CMD_APPEND_DOMAIN);
                o_cmd.append_p = accept && (cmd == CMD_APPEND_REF);
                o_cmd.start    = accept && (cmd == CMD_COMPARE);
            end
            ST_FIRST: begin
                o_cmd.capture = 1'b1;
                o_cmd.dec_d   = 1'b1;
                o_cmd.dec_p   = 1'b1;
            end
            ST_SECOND: begin
                o_cmd.capture = 1'b0;
            end
            ST_LOCK: begin
                if (i_status.d_end && i_status.p_end) begin
                    o_cmd.dec_d = label_next;
                    o_cmd.dec_p = label_next;
                end else if (!i_status.d_end && !i_status.p_end &&
                             i_status.d_name && i_status.eq_fold) begin
                    o_cmd.dec_d = 1'b1;
                    o_cmd.dec_p = 1'b1;
                end
            end
            ST_WILD: begin
                if (i_status.d_end) begin
                    o_cmd.dec_d = label_next;
                    o_cmd.dec_p = label_next;
                end else begin
                    o_cmd.dec_d = i_status.d_name;
                end
            end
            ST_FAIL: begin
                o_cmd.finish  = 1'b1;
                o_cmd.verdict = 1'b0;
            end
            ST_PASS: begin
                o_cmd.finish  = 1'b1;
                o_cmd.verdict = 1'b1;
            end
            default: begin
                o_cmd.finish = 1'b0;
            end
        endcase
    end

endmodule

@@ dv/wildcard_hostname_match_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the wildcard host-name matcher: a verdict scoreboard and random words.
module wildcard_hostname_match_top_tb import whm_pkg::*; ();

    localparam int NAME_CAP = MAX_NAME_LEN_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int RANDOM_WORDS = 480;

    typedef struct packed {
        logic matched;
        logic too_long;
    } t_verdict;

    class host_verdict_board;
        logic [7:0] dom_bytes [NAME_CAP];
        logic [7:0] pat_bytes [NAME_CAP];
        int dom_len;
        int pat_len;
        bit overflow;
        t_verdict verdict_q[$];
        int errors;

        function new();
            dom_len = 0;
            pat_len = 0;
            overflow = 0;
            errors = 0;
        endfunction

        function bit is_host_char(logic [7:0] c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h41 && c <= 8'h5A) || (c == CH_DASH);
        endfunction

        function logic [7:0] to_lower(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        endfunction

        function logic [7:0] byte_at(bit pat_side, int idx);
            return pat_side ? pat_bytes[idx] : dom_bytes[idx];
        endfunction

        // Text ends at the first zero byte or at the stored count.
        function int text_end(bit pat_side, int len);
            int i = 0;
            while (i < len && byte_at(pat_side, i) != 8'h00) i++;
            return i;
        endfunction

        // The last byte of a label is never taken as its separating dot.
        function int label_start(bit pat_side, int stop);
            for (int i = stop - 2; i >= 0; i--) begin
                if (byte_at(pat_side, i) == CH_DOT) return i + 1;
            end
            return 0;
        endfunction

        function bit labels_equal(int d0, int d1, int p0, int p1);
            logic [7:0] dc;
            logic [7:0] pc;
            if (p1 == p0 + 1 && pat_bytes[p0] == CH_STAR) begin
                for (int k = d0; k < d1; k++) begin
                    if (!is_host_char(dom_bytes[k])) return 0;
                end
                return 1;
            end
            if (d1 - d0 != p1 - p0) return 0;
            for (int k = 0; k < d1 - d0; k++) begin
                dc = dom_bytes[d0 + k];
                pc = pat_bytes[p0 + k];
                if (!is_host_char(dc)) return 0;
                if (dc != pc && to_lower(dc) != to_lower(pc)) return 0;
            end
            return 1;
        endfunction

        function bit predict_match();
            int dend;
            int pend;
            int d0;
            int p0;
            dend = text_end(0, dom_len);
            pend = text_end(1, pat_len);
            while (pend > 0 && dend > 0) begin
                p0 = label_start(1, pend);
                d0 = label_start(0, dend);
                if (!labels_equal(d0, dend, p0, pend)) return 0;
                dend = d0 - 1;
                pend = p0 - 1;
            end
            return (pend < 0 && dend < 0);
        endfunction

        function void note_word(t_cmd cmd, logic [7:0] b);
            t_verdict v;
            case (cmd)
                CMD_APPEND_DOMAIN: begin
                    if (dom_len < NAME_CAP) begin
                        dom_bytes[dom_len] = b;
                        dom_len++;
                    end else begin
                        overflow = 1;
                    end
                end
                CMD_APPEND_REF: begin
                    if (pat_len < NAME_CAP) begin
                        pat_bytes[pat_len] = b;
                        pat_len++;
                    end else begin
                        overflow = 1;
                    end
                end
                CMD_COMPARE: begin
                    v.matched = overflow ? 1'b0 : predict_match();
                    v.too_long = overflow;
                    verdict_q.push_back(v);
                    dom_len = 0;
                    pat_len = 0;
                    overflow = 0;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_verdict(logic matched, logic too_long);
            t_verdict v;
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: verdict expected none actual matched=%0b too_long=%0b",
                         $time, matched, too_long);
                return;
            end
            v = verdict_q.pop_front();
            if (matched !== v.matched) begin
                errors++;
                $display("%0t: matched expected %0b actual %0b", $time, v.matched, matched);
            end
            if (too_long !== v.too_long) begin
                errors++;
                $display("%0t: too_long expected %0b actual %0b",
                         $time, v.too_long, too_long);
            end
        endfunction

        function int outstanding();
            return verdict_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_command;
    logic [7:0] i_char_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_matched;
    logic       o_too_long;

    host_verdict_board sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int random_words = 0;
    int cycle_count = 0;
    logic [7:0] dom_text[$];
    logic [7:0] pat_text[$];

    wildcard_hostname_match_top #(
        .MAX_NAME_LEN(NAME_CAP)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_command(i_command),
        .i_char_byte(i_char_byte),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_matched(o_matched),
        .o_too_long(o_too_long)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_word(t_cmd'(i_command), i_char_byte);
        if (i_rst_n && o_valid && i_ready) sb.check_verdict(o_matched, o_too_long);
    end

    task automatic send_word(t_cmd cmd, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_char_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic run_case();
        int di;
        int pi;
        di = 0;
        pi = 0;
        while (di < dom_text.size() || pi < pat_text.size()) begin
            if ($urandom_range(99) < 3) send_word(CMD_NOP, 8'($urandom_range(255)));
            if (pi >= pat_text.size() || (di < dom_text.size() && $urandom_range(1) == 0)) begin
                send_word(CMD_APPEND_DOMAIN, dom_text[di]);
                di++;
            end else begin
                send_word(CMD_APPEND_REF, pat_text[pi]);
                pi++;
            end
        end
        send_word(CMD_COMPARE, 8'($urandom_range(255)));
        random_words += dom_text.size() + pat_text.size() + 1;
    endtask

    function automatic void set_case(string d, string p);
        dom_text.delete();
        pat_text.delete();
        for (int i = 0; i < d.len(); i++) dom_text.push_back(d[i]);
        for (int i = 0; i < p.len(); i++) pat_text.push_back(p[i]);
    endfunction

    function automatic logic [7:0] host_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return CH_DASH;
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
            $urandom_range(1) == 1) return c ^ 8'h20;
        return c;
    endfunction

    // Mostly well-formed names with a derived pattern; the rest is noise or broken.
    function automatic void make_case();
        int labels;
        int kind;
        int n;
        logic [7:0] lbl[$];
        dom_text.delete();
        pat_text.delete();
        kind = $urandom_range(99);
        if (kind < 10) begin
            n = $urandom_range(8);
            repeat (n) dom_text.push_back(8'($urandom_range(255)));
            n = $urandom_range(8);
            repeat (n) pat_text.push_back(8'($urandom_range(255)));
            return;
        end
        labels = $urandom_range(1, 4);
        for (int l = 0; l < labels; l++) begin
            if (l > 0) begin
                dom_text.push_back(CH_DOT);
                pat_text.push_back(CH_DOT);
            end
            n = $urandom_range(1, 6);
            lbl.delete();
            repeat (n) lbl.push_back(host_char());
            foreach (lbl[k]) dom_text.push_back(lbl[k]);
            kind = $urandom_range(99);
            if (kind < 20) begin
                pat_text.push_back(CH_STAR);
            end else if (kind < 24) begin
                pat_text.push_back(CH_STAR);
                pat_text.push_back(host_char());
            end else begin
                foreach (lbl[k]) pat_text.push_back(flip_case(lbl[k]));
                if (kind < 31) pat_text[pat_text.size() - 1] = 8'($urandom_range(255));
                else if (kind < 35) pat_text.push_back(host_char());
            end
        end
        kind = $urandom_range(99);
        if (kind < 5) begin
            dom_text.push_back(CH_DOT);
        end else if (kind < 10) begin
            pat_text.push_back(CH_DOT);
        end else if (kind < 14) begin
            dom_text.push_back(CH_DOT);
            pat_text.push_back(CH_DOT);
        end else if (kind < 18) begin
            pat_text.push_front(CH_DOT);
            pat_text.push_front(CH_STAR);
        end else if (kind < 21) begin
            dom_text.push_front(CH_DOT);
        end else if (kind < 24) begin
            dom_text.insert($urandom_range(dom_text.size()), 8'h00);
        end else if (kind < 26) begin
            pat_text.insert($urandom_range(pat_text.size()), 8'h00);
        end else if (kind < 28) begin
            dom_text.delete();
        end else if (kind < 30) begin
            pat_text.delete();
        end else if (kind < 33) begin
            dom_text[$urandom_range(dom_text.size() - 1)] = 8'($urandom_range(128, 255));
        end else if (kind < 36) begin
            dom_text.push_back(CH_DOT);
            dom_text.push_back(CH_DOT);
            pat_text.push_back(CH_DOT);
            pat_text.push_back(CH_DOT);
        end
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_NOP;
        i_char_byte = 8'h00;
        i_ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_case("a.b", "*.B");
        run_case();
        set_case("", "a");
        run_case();
        set_case("x.", "*");
        run_case();
        send_word(CMD_NOP, 8'hFF);
        set_case("z", "Z");
        dom_text.push_back(8'h00);
        run_case();
        set_case("", "");
        dom_text.push_back(8'hFF);
        pat_text.push_back(8'hFF);
        run_case();
        set_case("", "");
        run_case();

        // The domain store overflowing behind a wildcard pattern.
        set_case("", "*");
        repeat (NAME_CAP + 1) dom_text.push_back(8'h61);
        run_case();

        random_words = 0;
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            while (random_words < (phase + 1) * RANDOM_WORDS / 4) begin
                make_case();
                run_case();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
